[rtl/core/rppe_pkg.sv]
// shared types and constants for the robust peak-to-peak envelope block
// no dependencies; used by every module in rtl/core

package rppe_pkg;

    typedef enum logic [1:0] {
        OP_ADD   = 2'd0,
        OP_CLOSE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam int unsigned SUM_BITS = 22;
    localparam logic [SUM_BITS-1:0] SUM_MAX = {SUM_BITS{1'b1}};

    // one item moving from the input register into the result register
    typedef struct packed {
        logic fire;
        op_t  op;
    } step_t;

endpackage

[rtl/core/rppe_tracker.sv]
// window trackers: smallest, second smallest, largest, second largest
// depends on rppe_pkg

module rppe_tracker #(
    parameter int unsigned SAMPLE_BITS = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  rppe_pkg::step_t        step,
    input  logic [SAMPLE_BITS-1:0] sample,
    output logic [SAMPLE_BITS-1:0] low_second,
    output logic [SAMPLE_BITS-1:0] high_second,
    output logic                   win_full
);

    logic [SAMPLE_BITS-1:0] low_first_reg,   low_first_next;
    logic [SAMPLE_BITS-1:0] low_second_reg,  low_second_next;
    logic [SAMPLE_BITS-1:0] high_first_reg,  high_first_next;
    logic [SAMPLE_BITS-1:0] high_second_reg, high_second_next;
    logic [1:0]             seen_reg,        seen_next;

    always_comb begin
        low_first_next   = low_first_reg;
        low_second_next  = low_second_reg;
        high_first_next  = high_first_reg;
        high_second_next = high_second_reg;
        seen_next        = seen_reg;
        if (step.fire) begin
            unique case (step.op)
                rppe_pkg::OP_ADD: begin
                    if (seen_reg == 2'd0) begin
                        low_first_next   = sample;
                        high_first_next  = sample;
                        low_second_next  = '0;
                        high_second_next = '0;
                        seen_next        = 2'd1;
                    end else if (seen_reg == 2'd1) begin
                        // second sample always fills the second slots
                        if (sample < low_first_reg) begin
                            low_second_next = low_first_reg;
                            low_first_next  = sample;
                        end else begin
                            low_second_next = sample;
                        end
                        if (sample > high_first_reg) begin
                            high_second_next = high_first_reg;
                            high_first_next  = sample;
                        end else begin
                            high_second_next = sample;
                        end
                        seen_next = 2'd2;
                    end else begin
                        if (sample < low_first_reg) begin
                            low_second_next = low_first_reg;
                            low_first_next  = sample;
                        end else if (sample < low_second_reg) begin
                            low_second_next = sample;
                        end
                        if (sample > high_first_reg) begin
                            high_second_next = high_first_reg;
                            high_first_next  = sample;
                        end else if (sample > high_second_reg) begin
                            high_second_next = sample;
                        end
                    end
                end
                rppe_pkg::OP_CLOSE: begin
                    seen_next = 2'd0;
                end
                rppe_pkg::OP_CLEAR,
                rppe_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 2'd0;
        end else begin
            seen_reg <= seen_next;
        end
    end

    // tracker values are only read once the window holds two samples
    always_ff @(posedge aclk) begin
        low_first_reg   <= low_first_next;
        low_second_reg  <= low_second_next;
        high_first_reg  <= high_first_next;
        high_second_reg <= high_second_next;
    end

    assign low_second  = low_second_reg;
    assign high_second = high_second_reg;
    assign win_full    = (seen_reg == 2'd2);

endmodule

[rtl/core/rppe_accum.sv]
// span computation and saturating span sum / window count
// depends on rppe_pkg

module rppe_accum #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned MAX_WINDOWS = 1024,
    parameter int unsigned COUNT_BITS  = $clog2(MAX_WINDOWS + 1)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rppe_pkg::step_t               step,
    input  logic [SAMPLE_BITS-1:0]        low_second,
    input  logic [SAMPLE_BITS-1:0]        high_second,
    input  logic                          win_full,
    output logic [rppe_pkg::SUM_BITS-1:0] span_sum,
    output logic [COUNT_BITS-1:0]         window_count,
    output logic [SAMPLE_BITS-1:0]        last_span,
    output logic                          span_valid
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = COUNT_BITS'(MAX_WINDOWS);

    logic [rppe_pkg::SUM_BITS-1:0] sum_reg,   sum_next;
    logic [COUNT_BITS-1:0]         count_reg, count_next;
    logic [SAMPLE_BITS-1:0]        span;
    logic [rppe_pkg::SUM_BITS:0]   sum_wide;
    logic                          closing;

    assign span     = (high_second > low_second) ? (high_second - low_second) : '0;
    assign sum_wide = {1'b0, sum_reg} + (rppe_pkg::SUM_BITS + 1)'(span);
    assign closing  = step.fire && (step.op == rppe_pkg::OP_CLOSE) && win_full;

    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (step.fire) begin
            unique case (step.op)
                rppe_pkg::OP_CLOSE: begin
                    if (win_full) begin
                        sum_next = sum_wide[rppe_pkg::SUM_BITS]
                                   ? rppe_pkg::SUM_MAX
                                   : sum_wide[rppe_pkg::SUM_BITS-1:0];
                        if (count_reg < COUNT_MAX) begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                end
                rppe_pkg::OP_CLEAR: begin
                    sum_next   = '0;
                    count_next = '0;
                end
                rppe_pkg::OP_ADD,
                rppe_pkg::OP_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg   <= '0;
            count_reg <= '0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // result fields reflect the state after this item
    assign span_sum     = sum_next;
    assign window_count = count_next;
    assign last_span    = closing ? span : '0;
    assign span_valid   = closing;

endmodule

[rtl/core/robust_peak_to_peak_envelope.sv]
// top level: input register, tracker and accumulator, result register
// depends on rppe_pkg, rppe_tracker, rppe_accum
//
//  channel | direction | tdata (low bit up)                      | tuser
//  s_      | in        | sample                                  | op
//  m_      | out       | span_sum, window_count, last_span       | span_valid
//
// one beat in and one beat out per cycle when neither side stalls; each beat passes
// through the input register and then the result register
// aresetn is synchronous and active low; it clears both valid flags, the window
// sample count and the accumulators
// a stalled result beat holds in the result register while one more input beat
// waits in the input register; s_tready drops only when both are full

module robust_peak_to_peak_envelope #(
    parameter int unsigned SAMPLE_BITS = 12,
    parameter int unsigned MAX_WINDOWS = 1024,
    localparam int unsigned IN_W       = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int unsigned COUNT_BITS = $clog2(MAX_WINDOWS + 1),
    localparam int unsigned OUT_RAW    = rppe_pkg::SUM_BITS + COUNT_BITS + SAMPLE_BITS,
    localparam int unsigned OUT_W      = ((OUT_RAW + 7) / 8) * 8
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [IN_W-1:0]         s_tdata,   // sample
    input  logic [1:0]              s_tuser,   // op
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [OUT_W-1:0]        m_tdata,   // span_sum, window_count, last_span
    output logic                    m_tuser    // span_valid
);

    logic                   in_valid_reg;
    rppe_pkg::op_t          in_op_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;
    logic                   out_valid_reg;
    logic [OUT_W-1:0]       out_data_reg;
    logic                   out_user_reg;

    logic                          advance;
    rppe_pkg::step_t               step;
    logic [SAMPLE_BITS-1:0]        low_second;
    logic [SAMPLE_BITS-1:0]        high_second;
    logic                          win_full;
    logic [rppe_pkg::SUM_BITS-1:0] span_sum;
    logic [COUNT_BITS-1:0]         window_count;
    logic [SAMPLE_BITS-1:0]        last_span;
    logic                          span_valid;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign step.fire = advance;
    assign step.op   = in_op_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_op_reg     <= rppe_pkg::op_t'(s_tuser);
            in_sample_reg <= s_tdata[SAMPLE_BITS-1:0];
        end
        if (advance) begin
            out_data_reg <= OUT_W'({last_span, window_count, span_sum});
            out_user_reg <= span_valid;
        end
    end

    rppe_tracker #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_tracker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .sample     (in_sample_reg),
        .low_second (low_second),
        .high_second(high_second),
        .win_full   (win_full)
    );

    rppe_accum #(
        .SAMPLE_BITS(SAMPLE_BITS),
        .MAX_WINDOWS(MAX_WINDOWS),
        .COUNT_BITS (COUNT_BITS)
    ) u_accum (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .low_second  (low_second),
        .high_second (high_second),
        .win_full    (win_full),
        .span_sum    (span_sum),
        .window_count(window_count),
        .last_span   (last_span),
        .span_valid  (span_valid)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

[tb/envelope_checker.sv]
`timescale 1ns / 1ps
// checker for the peak-to-peak envelope block: predicts every result beat from the
// accepted input beats and compares it field by field; depends on rppe_pkg

module envelope_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,   // sample
    input  logic [1:0]  s_tuser,   // op
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,   // span_sum, window_count, last_span
    input  logic        m_tuser,   // span_valid
    output int          mismatches,
    output int          outstanding,
    output int          beats_checked,
    output int          valid_spans,
    output logic        sum_saturated,
    output logic        count_saturated
);

    localparam int unsigned MAX_WINDOWS = 1024;
    localparam int unsigned COUNT_BITS  = 11;
    localparam int unsigned SAMPLE_BITS = 12;
    localparam int unsigned SUM_BITS    = rppe_pkg::SUM_BITS;

    typedef struct packed {
        logic [SUM_BITS-1:0]    span_sum;
        logic [COUNT_BITS-1:0]  window_count;
        logic [SAMPLE_BITS-1:0] last_span;
        logic                   span_valid;
    } envelope_t;

    logic [SAMPLE_BITS-1:0] low_min, low_next, high_max, high_next;
    logic [1:0]             window_fill;
    logic [SUM_BITS-1:0]    span_acc;
    logic [COUNT_BITS-1:0]  window_acc;
    envelope_t              pending_envelopes[$];
    int                     fail_tally;
    int                     checked;
    int                     spans;
    logic                   sum_hit;
    logic                   count_hit;

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t ns: %s", $time, msg);
        fail_tally++;
    endtask

    task automatic advance_envelope(input rppe_pkg::op_t op,
                                    input logic [SAMPLE_BITS-1:0] smp);
        envelope_t           res;
        logic [SAMPLE_BITS-1:0] span;
        logic [SUM_BITS:0]   wide_sum;
        span = '0;
        res.span_valid = 1'b0;
        case (op)
            rppe_pkg::OP_ADD: begin
                if (window_fill == 2'd0) begin
                    low_min     = smp;
                    high_max    = smp;
                    low_next    = '0;
                    high_next   = '0;
                    window_fill = 2'd1;
                end else if (window_fill == 2'd1) begin
                    // second sample always fills the second slots, ties included
                    if (smp < low_min) begin
                        low_next = low_min;
                        low_min  = smp;
                    end else begin
                        low_next = smp;
                    end
                    if (smp > high_max) begin
                        high_next = high_max;
                        high_max  = smp;
                    end else begin
                        high_next = smp;
                    end
                    window_fill = 2'd2;
                end else begin
                    if (smp < low_min) begin
                        low_next = low_min;
                        low_min  = smp;
                    end else if (smp < low_next) begin
                        low_next = smp;
                    end
                    if (smp > high_max) begin
                        high_next = high_max;
                        high_max  = smp;
                    end else if (smp > high_next) begin
                        high_next = smp;
                    end
                end
            end
            rppe_pkg::OP_CLOSE: begin
                if (window_fill == 2'd2) begin
                    res.span_valid = 1'b1;
                    span = (high_next > low_next) ? high_next - low_next : '0;
                    wide_sum = span_acc + span;
                    span_acc = (wide_sum > {1'b0, rppe_pkg::SUM_MAX})
                               ? rppe_pkg::SUM_MAX : wide_sum[SUM_BITS-1:0];
                    if (window_acc < MAX_WINDOWS) window_acc++;
                    spans++;
                end
                low_min     = '0;
                low_next    = '0;
                high_max    = '0;
                high_next   = '0;
                window_fill = 2'd0;
            end
            rppe_pkg::OP_CLEAR: begin
                // the open window survives a clear
                span_acc   = '0;
                window_acc = '0;
            end
            default: ;
        endcase
        res.span_sum     = span_acc;
        res.window_count = window_acc;
        res.last_span    = span;
        if (span_acc == rppe_pkg::SUM_MAX) sum_hit = 1'b1;
        if (window_acc == MAX_WINDOWS) count_hit = 1'b1;
        pending_envelopes.push_back(res);
    endtask

    always @(posedge aclk) begin
        envelope_t              want;
        logic [SUM_BITS-1:0]    got_sum;
        logic [COUNT_BITS-1:0]  got_count;
        logic [SAMPLE_BITS-1:0] got_span;
        if (!aresetn) begin
            low_min     = '0;
            low_next    = '0;
            high_max    = '0;
            high_next   = '0;
            window_fill = 2'd0;
            span_acc    = '0;
            window_acc  = '0;
            fail_tally  = 0;
            checked     = 0;
            spans       = 0;
            sum_hit     = 1'b0;
            count_hit   = 1'b0;
            pending_envelopes.delete();
        end else begin
            // retire the result first so that a beat in and a beat out on one edge stay apart
            if (m_tvalid && m_tready) begin
                got_sum   = m_tdata[SUM_BITS-1:0];
                got_count = m_tdata[SUM_BITS +: COUNT_BITS];
                got_span  = m_tdata[SUM_BITS+COUNT_BITS +: SAMPLE_BITS];
                if (pending_envelopes.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    want = pending_envelopes.pop_front();
                    if (got_sum !== want.span_sum)
                        report_mismatch($sformatf("beat %0d span_sum got %0d want %0d",
                                                  checked, got_sum, want.span_sum));
                    if (got_count !== want.window_count)
                        report_mismatch($sformatf("beat %0d window_count got %0d want %0d",
                                                  checked, got_count, want.window_count));
                    if (got_span !== want.last_span)
                        report_mismatch($sformatf("beat %0d last_span got %0d want %0d",
                                                  checked, got_span, want.last_span));
                    if (m_tuser !== want.span_valid)
                        report_mismatch($sformatf("beat %0d span_valid got %0b want %0b",
                                                  checked, m_tuser, want.span_valid));
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
                advance_envelope(rppe_pkg::op_t'(s_tuser), s_tdata[SAMPLE_BITS-1:0]);
        end
        mismatches      <= fail_tally;
        outstanding     <= pending_envelopes.size();
        beats_checked   <= checked;
        valid_spans     <= spans;
        sum_saturated   <= sum_hit;
        count_saturated <= count_hit;
    end

endmodule

[tb/tb_robust_peak_to_peak_envelope.sv]
`timescale 1ns / 1ps
// top of the envelope testbench: clock, reset, input beats and result back-pressure
// depends on rppe_pkg, robust_peak_to_peak_envelope and envelope_checker

module tb_robust_peak_to_peak_envelope;

    localparam int RANDOM_ITEMS       = 650;
    localparam int WIDE_WINDOWS       = 70;
    localparam int IDLE_PCT           = 22;
    localparam int HOLD_CYCLES        = 64;
    localparam int STALL_LIMIT        = 1000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;   // sample
    logic [1:0]  s_tuser;   // op
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;   // span_sum, window_count, last_span
    logic        m_tuser;   // span_valid

    int   mismatches;
    int   outstanding;
    int   beats_checked;
    int   valid_spans;
    logic sum_saturated;
    logic count_saturated;

    int items_sent   = 0;
    int idle_cycles  = 0;
    bit calm         = 1'b0;
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    robust_peak_to_peak_envelope dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    envelope_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .beats_checked   (beats_checked),
        .valid_spans     (valid_spans),
        .sum_saturated   (sum_saturated),
        .count_saturated (count_saturated)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    task automatic send_beat(input rppe_pkg::op_t op, input logic [11:0] smp);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {4'b0000, smp};
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic send_window();
        int          len;
        int          flavor;
        int          r;
        logic [11:0] base;
        logic [11:0] smp;
        r = $urandom_range(0, 99);
        if (r < 8) len = $urandom_range(0, 1);
        else if (r < 22) len = 2;
        else len = $urandom_range(3, 8);
        flavor = $urandom_range(0, 2);
        base   = 12'($urandom_range(0, 4093));
        for (int i = 0; i < len; i++) begin
            case (flavor)
                0: smp = 12'($urandom_range(0, 4095));
                // narrow band so that ties on the extremes are common
                1: smp = base + 12'($urandom_range(0, 2));
                default: smp = ($urandom_range(0, 1) != 0) ? 12'hfff : 12'h000;
            endcase
            send_beat(rppe_pkg::OP_ADD, smp);
        end
        send_beat(rppe_pkg::OP_CLOSE, 12'($urandom_range(0, 4095)));
    endtask

    initial begin
        int          r;
        int          start;
        int          j;
        logic [11:0] quad [4];
        logic [11:0] tmp;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= rppe_pkg::OP_ADD;
        aresetn  <= 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // short windows, then the empty one
        send_beat(rppe_pkg::OP_ADD, 12'd4095);
        send_beat(rppe_pkg::OP_CLOSE, 12'd0);
        send_beat(rppe_pkg::OP_CLOSE, 12'd4095);
        // two equal samples
        send_beat(rppe_pkg::OP_ADD, 12'd7);
        send_beat(rppe_pkg::OP_ADD, 12'd7);
        send_beat(rppe_pkg::OP_CLOSE, 12'd0);
        // two samples, second largest below second smallest
        send_beat(rppe_pkg::OP_ADD, 12'd100);
        send_beat(rppe_pkg::OP_ADD, 12'd3000);
        send_beat(rppe_pkg::OP_CLOSE, 12'd0);
        // full-scale span with a late tie on the top
        send_beat(rppe_pkg::OP_ADD, 12'd0);
        send_beat(rppe_pkg::OP_ADD, 12'd4095);
        send_beat(rppe_pkg::OP_ADD, 12'd0);
        send_beat(rppe_pkg::OP_ADD, 12'd4095);
        send_beat(rppe_pkg::OP_ADD, 12'd4095);
        send_beat(rppe_pkg::OP_CLOSE, 12'd0);
        send_beat(rppe_pkg::OP_NONE, 12'd4095);
        // clear in the middle of an open window
        send_beat(rppe_pkg::OP_ADD, 12'd10);
        send_beat(rppe_pkg::OP_ADD, 12'd20);
        send_beat(rppe_pkg::OP_CLEAR, 12'd0);
        send_beat(rppe_pkg::OP_ADD, 12'd30);
        send_beat(rppe_pkg::OP_ADD, 12'd5);
        send_beat(rppe_pkg::OP_CLOSE, 12'd0);
        send_beat(rppe_pkg::OP_ADD, 12'd2048);
        send_beat(rppe_pkg::OP_ADD, 12'd1);
        send_beat(rppe_pkg::OP_ADD, 12'd4094);
        send_beat(rppe_pkg::OP_CLOSE, 12'd4095);

        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            calm = (items_sent - start >= 500) && (items_sent - start < 700);
            if (items_sent - start >= 300) squeeze_req = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 80) send_window();
            else if (r < 86) send_beat(rppe_pkg::OP_CLEAR, 12'($urandom_range(0, 4095)));
            else if (r < 92) send_beat(rppe_pkg::OP_NONE, 12'($urandom_range(0, 4095)));
            else send_beat(rppe_pkg::op_t'($urandom_range(0, 3)),
                           12'($urandom_range(0, 4095)));
        end
        calm = 1'b0;

        // wide windows from zero so the sum climbs in large steps
        send_beat(rppe_pkg::OP_CLEAR, 12'($urandom_range(0, 4095)));
        repeat (WIDE_WINDOWS) begin
            quad[0] = 12'd4095 - 12'($urandom_range(0, 90));
            quad[1] = 12'd4095 - 12'($urandom_range(0, 90));
            quad[2] = 12'($urandom_range(0, 90));
            quad[3] = 12'($urandom_range(0, 90));
            for (int k = 3; k > 0; k--) begin
                j       = $urandom_range(0, k);
                tmp     = quad[k];
                quad[k] = quad[j];
                quad[j] = tmp;
            end
            foreach (quad[k]) send_beat(rppe_pkg::OP_ADD, quad[k]);
            send_beat(rppe_pkg::OP_CLOSE, 12'($urandom_range(0, 4095)));
        end
        send_beat(rppe_pkg::OP_CLEAR, 12'($urandom_range(0, 4095)));
        repeat (20) send_window();
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        $display("run covered %0d input beats, %0d checked result beats, %0d valid windows",
                 items_sent, beats_checked, valid_spans);
        $display("span sum saturation reached: %0d, window count saturation reached: %0d",
                 sum_saturated, count_saturated);
        if (mismatches == 0 && outstanding == 0) begin
            $display("tb_robust_peak_to_peak_envelope passed");
        end else begin
            $display("tb_robust_peak_to_peak_envelope failed");
        end
        $finish;
    end

    // result side: random back-pressure plus one long hold-off to fill the block
    initial begin
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (squeeze_req && !squeeze_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                squeeze_done = 1'b1;
            end
            m_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_robust_peak_to_peak_envelope failed");
                $finish;
            end
        end
    end

endmodule
